// ----- design/dpb_pkg.sv -----
// Shared types and constants for the depth pixel back-projection unit.
// Used by every module under design/; depends on nothing else.
// Holds widths, register codes, configuration and payload structs.
package dpb_pkg;

    // Pixel coordinate width; region registers share it
    localparam int COORD_BITS = 12;
    localparam int DEPTH_W    = 16;
    localparam int FOCAL_W    = 16;
    localparam int CENTRE_W   = 16;
    localparam int COLOUR_W   = 8;
    localparam int POINT_W    = 32;

    // Derived datapath widths
    localparam int SCALED_W = COORD_BITS + 4;
    localparam int DIFF_W   = ((SCALED_W > CENTRE_W) ? SCALED_W : CENTRE_W) + 1;
    localparam int ABS_W    = DIFF_W - 1;
    localparam int MAG_W    = ABS_W + DEPTH_W;
    localparam int DVD_W    = MAG_W + 4;

    // APB register file
    localparam int REG_COUNT = 8;
    localparam int IDX_W     = $clog2(REG_COUNT);
    localparam int ADDR_W    = IDX_W + 2;
    localparam int DATA_W    = 32;

    typedef enum logic [IDX_W-1:0] {
        REG_FOCAL_X,
        REG_FOCAL_Y,
        REG_CENTRE_X,
        REG_CENTRE_Y,
        REG_REGION_LEFT,
        REG_REGION_TOP,
        REG_REGION_WIDTH,
        REG_REGION_HEIGHT
    } dpb_reg_t;

    typedef struct packed {
        logic [FOCAL_W-1:0]    focal_x;
        logic [FOCAL_W-1:0]    focal_y;
        logic [CENTRE_W-1:0]   centre_x;
        logic [CENTRE_W-1:0]   centre_y;
        logic [COORD_BITS-1:0] region_left;
        logic [COORD_BITS-1:0] region_top;
        logic [COORD_BITS-1:0] region_width;
        logic [COORD_BITS-1:0] region_height;
    } dpb_cfg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic [DEPTH_W-1:0]    depth_mm;
        logic [COLOUR_W-1:0]   blue;
        logic [COLOUR_W-1:0]   green;
        logic [COLOUR_W-1:0]   red;
        logic                  colour_present;
    } dpb_pixel_t;

    typedef struct packed {
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_y;
        logic [DEPTH_W-1:0]        point_z;
        logic [COLOUR_W-1:0]       out_red;
        logic [COLOUR_W-1:0]       out_green;
        logic [COLOUR_W-1:0]       out_blue;
    } dpb_point_t;

    // One slot of the divider chain: flags, carried payload and both lanes.
    // dvd holds the remaining dividend bits and, shifted in at the bottom,
    // the quotient bits produced so far.
    typedef struct packed {
        logic                valid;
        logic                neg_x;
        logic                nz_x;
        logic                neg_y;
        logic                nz_y;
        logic [DEPTH_W-1:0]  point_z;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
        logic [FOCAL_W-1:0]  rem_x;
        logic [DVD_W-1:0]    dvd_x;
        logic [FOCAL_W-1:0]  rem_y;
        logic [DVD_W-1:0]    dvd_y;
    } dpb_stage_t;

endpackage

// ----- design/dpb_regs.sv -----
// APB configuration registers for the back-projection unit.
// Depends on dpb_pkg for register codes and the configuration struct.
module dpb_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dpb_pkg::ADDR_W-1:0] paddr,
    input  logic [dpb_pkg::DATA_W-1:0] pwdata,
    output logic [dpb_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output dpb_pkg::dpb_cfg_t          cfg
);

    dpb_pkg::dpb_cfg_t cfg_reg;
    dpb_pkg::dpb_reg_t index;
    logic              wr_en;

    assign index  = dpb_pkg::dpb_reg_t'(paddr[dpb_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x       <= dpb_pkg::FOCAL_W'(9600);
            cfg_reg.focal_y       <= dpb_pkg::FOCAL_W'(9600);
            cfg_reg.centre_x      <= dpb_pkg::CENTRE_W'(10240);
            cfg_reg.centre_y      <= dpb_pkg::CENTRE_W'(5760);
            cfg_reg.region_left   <= '0;
            cfg_reg.region_top    <= '0;
            cfg_reg.region_width  <= '1;
            cfg_reg.region_height <= '1;
        end
        else if (wr_en)
        begin
            case (index)
                dpb_pkg::REG_FOCAL_X:
                    cfg_reg.focal_x <= pwdata[dpb_pkg::FOCAL_W-1:0];
                dpb_pkg::REG_FOCAL_Y:
                    cfg_reg.focal_y <= pwdata[dpb_pkg::FOCAL_W-1:0];
                dpb_pkg::REG_CENTRE_X:
                    cfg_reg.centre_x <= pwdata[dpb_pkg::CENTRE_W-1:0];
                dpb_pkg::REG_CENTRE_Y:
                    cfg_reg.centre_y <= pwdata[dpb_pkg::CENTRE_W-1:0];
                dpb_pkg::REG_REGION_LEFT:
                    cfg_reg.region_left <= pwdata[dpb_pkg::COORD_BITS-1:0];
                dpb_pkg::REG_REGION_TOP:
                    cfg_reg.region_top <= pwdata[dpb_pkg::COORD_BITS-1:0];
                dpb_pkg::REG_REGION_WIDTH:
                    cfg_reg.region_width <= pwdata[dpb_pkg::COORD_BITS-1:0];
                dpb_pkg::REG_REGION_HEIGHT:
                    cfg_reg.region_height <= pwdata[dpb_pkg::COORD_BITS-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (index)
            dpb_pkg::REG_FOCAL_X:       prdata = dpb_pkg::DATA_W'(cfg_reg.focal_x);
            dpb_pkg::REG_FOCAL_Y:       prdata = dpb_pkg::DATA_W'(cfg_reg.focal_y);
            dpb_pkg::REG_CENTRE_X:      prdata = dpb_pkg::DATA_W'(cfg_reg.centre_x);
            dpb_pkg::REG_CENTRE_Y:      prdata = dpb_pkg::DATA_W'(cfg_reg.centre_y);
            dpb_pkg::REG_REGION_LEFT:   prdata = dpb_pkg::DATA_W'(cfg_reg.region_left);
            dpb_pkg::REG_REGION_TOP:    prdata = dpb_pkg::DATA_W'(cfg_reg.region_top);
            dpb_pkg::REG_REGION_WIDTH:  prdata = dpb_pkg::DATA_W'(cfg_reg.region_width);
            dpb_pkg::REG_REGION_HEIGHT: prdata = dpb_pkg::DATA_W'(cfg_reg.region_height);
            default:                    prdata = '0;
        endcase
    end

endmodule

// ----- design/dpb_prep.sv -----
// Front end: region/depth filter, centre offset and depth multiply.
// Two register stages; feeds the first divider cell. Depends on dpb_pkg.
module dpb_prep (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                pixel_valid,
    input  dpb_pkg::dpb_pixel_t pixel,
    input  dpb_pkg::dpb_cfg_t   cfg,
    output dpb_pkg::dpb_stage_t stage_out
);

    localparam int CW = dpb_pkg::COORD_BITS + 1;

    // Stage A registers
    logic                             a_valid_reg, a_valid_next;
    logic                             a_neg_x_reg, a_neg_x_next;
    logic                             a_nz_x_reg, a_nz_x_next;
    logic                             a_neg_y_reg, a_neg_y_next;
    logic                             a_nz_y_reg, a_nz_y_next;
    logic [dpb_pkg::ABS_W-1:0]        a_abs_x_reg, a_abs_x_next;
    logic [dpb_pkg::ABS_W-1:0]        a_abs_y_reg, a_abs_y_next;
    logic [dpb_pkg::DEPTH_W-1:0]      a_depth_reg;
    logic [dpb_pkg::COLOUR_W-1:0]     a_red_reg, a_green_reg, a_blue_reg;
    logic [dpb_pkg::COLOUR_W-1:0]     red_next, green_next, blue_next;

    // Stage B register and next value
    dpb_pkg::dpb_stage_t              b_reg, b_next;

    logic [dpb_pkg::DIFF_W-1:0]       diff_x, diff_y;
    logic [dpb_pkg::DIFF_W-1:0]       neg_diff_x, neg_diff_y;
    logic [dpb_pkg::SCALED_W-1:0]     scaled_x, scaled_y;
    logic                             in_cols, in_rows;
    logic [dpb_pkg::MAG_W-1:0]        mag_x, mag_y;

    // Filter and signed offset from the principal point
    always_comb
    begin
        in_cols = (pixel.column >= cfg.region_left) &&
                  (CW'(pixel.column) < CW'(cfg.region_left) + CW'(cfg.region_width));
        in_rows = (pixel.row >= cfg.region_top) &&
                  (CW'(pixel.row) < CW'(cfg.region_top) + CW'(cfg.region_height));
        a_valid_next = pixel_valid && (pixel.depth_mm != '0) && in_cols && in_rows;

        scaled_x   = {pixel.column, 4'b0000};
        scaled_y   = {pixel.row, 4'b0000};
        diff_x     = dpb_pkg::DIFF_W'(scaled_x) - dpb_pkg::DIFF_W'(cfg.centre_x);
        diff_y     = dpb_pkg::DIFF_W'(scaled_y) - dpb_pkg::DIFF_W'(cfg.centre_y);
        neg_diff_x = -diff_x;
        neg_diff_y = -diff_y;

        a_neg_x_next = diff_x[dpb_pkg::DIFF_W-1];
        a_neg_y_next = diff_y[dpb_pkg::DIFF_W-1];
        a_nz_x_next  = (diff_x != '0);
        a_nz_y_next  = (diff_y != '0);
        a_abs_x_next = a_neg_x_next ? neg_diff_x[dpb_pkg::ABS_W-1:0]
                                    : diff_x[dpb_pkg::ABS_W-1:0];
        a_abs_y_next = a_neg_y_next ? neg_diff_y[dpb_pkg::ABS_W-1:0]
                                    : diff_y[dpb_pkg::ABS_W-1:0];

        // White when no colour pixel
        red_next   = pixel.colour_present ? pixel.red   : '1;
        green_next = pixel.colour_present ? pixel.green : '1;
        blue_next  = pixel.colour_present ? pixel.blue  : '1;
    end

    // Stage A control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    // Stage A payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_neg_x_reg <= a_neg_x_next;
            a_nz_x_reg  <= a_nz_x_next;
            a_neg_y_reg <= a_neg_y_next;
            a_nz_y_reg  <= a_nz_y_next;
            a_abs_x_reg <= a_abs_x_next;
            a_abs_y_reg <= a_abs_y_next;
            a_depth_reg <= pixel.depth_mm;
            a_red_reg   <= red_next;
            a_green_reg <= green_next;
            a_blue_reg  <= blue_next;
        end
    end

    // |offset| * depth, then the extra x16 as four zero bits
    assign mag_x = dpb_pkg::MAG_W'(a_abs_x_reg) * dpb_pkg::MAG_W'(a_depth_reg);
    assign mag_y = dpb_pkg::MAG_W'(a_abs_y_reg) * dpb_pkg::MAG_W'(a_depth_reg);

    always_comb
    begin
        b_next.valid   = a_valid_reg;
        b_next.neg_x   = a_neg_x_reg;
        b_next.nz_x    = a_nz_x_reg;
        b_next.neg_y   = a_neg_y_reg;
        b_next.nz_y    = a_nz_y_reg;
        b_next.point_z = a_depth_reg;
        b_next.red     = a_red_reg;
        b_next.green   = a_green_reg;
        b_next.blue    = a_blue_reg;
        b_next.rem_x   = '0;
        b_next.dvd_x   = {mag_x, 4'b0000};
        b_next.rem_y   = '0;
        b_next.dvd_y   = {mag_y, 4'b0000};
    end

    // Stage B
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else if (advance)
        begin
            b_reg <= b_next;
        end
    end

    assign stage_out = b_reg;

endmodule

// ----- design/dpb_div_cell.sv -----
// One cell of the restoring divider chain: one quotient bit for x and y.
// Hands its slot to the next cell each advancing cycle. Depends on dpb_pkg.
module dpb_div_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic [dpb_pkg::FOCAL_W-1:0]  focal_x,
    input  logic [dpb_pkg::FOCAL_W-1:0]  focal_y,
    input  dpb_pkg::dpb_stage_t          stage_in,
    output dpb_pkg::dpb_stage_t          stage_out
);

    localparam int TW = dpb_pkg::FOCAL_W + 1;

    dpb_pkg::dpb_stage_t stage_reg, stage_next;
    logic [TW-1:0]       trial_x, trial_y;
    logic [TW-1:0]       diff_x, diff_y;
    logic                ge_x, ge_y;

    // Shift in the next dividend bit, subtract the divisor when it fits
    always_comb
    begin
        trial_x = {stage_in.rem_x, stage_in.dvd_x[dpb_pkg::DVD_W-1]};
        trial_y = {stage_in.rem_y, stage_in.dvd_y[dpb_pkg::DVD_W-1]};
        ge_x    = (trial_x >= TW'(focal_x));
        ge_y    = (trial_y >= TW'(focal_y));
        diff_x  = trial_x - TW'(focal_x);
        diff_y  = trial_y - TW'(focal_y);

        stage_next       = stage_in;
        stage_next.rem_x = ge_x ? diff_x[dpb_pkg::FOCAL_W-1:0]
                                : trial_x[dpb_pkg::FOCAL_W-1:0];
        stage_next.rem_y = ge_y ? diff_y[dpb_pkg::FOCAL_W-1:0]
                                : trial_y[dpb_pkg::FOCAL_W-1:0];
        stage_next.dvd_x = {stage_in.dvd_x[dpb_pkg::DVD_W-2:0], ge_x};
        stage_next.dvd_y = {stage_in.dvd_y[dpb_pkg::DVD_W-2:0], ge_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// ----- design/dpb_post.sv -----
// Back end: sign, saturation and zero-focal handling, then the output register.
// Takes the last divider cell's slot. Depends on dpb_pkg.
module dpb_post (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic [dpb_pkg::FOCAL_W-1:0]  focal_x,
    input  logic [dpb_pkg::FOCAL_W-1:0]  focal_y,
    input  dpb_pkg::dpb_stage_t          stage_in,
    output logic                         point_valid,
    output dpb_pkg::dpb_point_t          point
);

    localparam logic [dpb_pkg::POINT_W-1:0] SAT_MAX = {1'b0, {(dpb_pkg::POINT_W-1){1'b1}}};
    localparam logic [dpb_pkg::POINT_W-1:0] SAT_MIN = {1'b1, {(dpb_pkg::POINT_W-1){1'b0}}};

    logic                valid_reg;
    dpb_pkg::dpb_point_t point_reg, point_next;

    // Signed, saturated result from the quotient magnitude
    function automatic logic [dpb_pkg::POINT_W-1:0] finish(
        input logic [dpb_pkg::DVD_W-1:0]   quo,
        input logic                        neg,
        input logic                        nz,
        input logic [dpb_pkg::FOCAL_W-1:0] den
    );
        logic [dpb_pkg::POINT_W-1:0] res;
        begin
            if (!nz)
                res = '0;
            else if (den == '0)
                res = neg ? SAT_MIN : SAT_MAX;
            else if (!neg)
                res = (quo > dpb_pkg::DVD_W'(SAT_MAX)) ? SAT_MAX
                                                        : quo[dpb_pkg::POINT_W-1:0];
            else
                res = (quo > dpb_pkg::DVD_W'(SAT_MIN)) ? SAT_MIN
                                                        : -quo[dpb_pkg::POINT_W-1:0];
            return res;
        end
    endfunction

    always_comb
    begin
        point_next.point_x   = $signed(finish(stage_in.dvd_x, stage_in.neg_x,
                                              stage_in.nz_x, focal_x));
        point_next.point_y   = $signed(finish(stage_in.dvd_y, stage_in.neg_y,
                                              stage_in.nz_y, focal_y));
        point_next.point_z   = stage_in.point_z;
        point_next.out_red   = stage_in.red;
        point_next.out_green = stage_in.green;
        point_next.out_blue  = stage_in.blue;
    end

    // Output register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage_in.valid;
        end
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            point_reg <= point_next;
        end
    end

    assign point_valid = valid_reg;
    assign point       = point_reg;

endmodule

// ----- design/depth_pixel_backprojection_unit.sv -----
// Depth pixel back-projection unit: pinhole model, one pixel to one point.
// Pipeline: two front-end stages, one divider cell per quotient bit and one
// output register.
// Throughput: one pixel per cycle while not stalled; the whole chain advances
// whenever the output register is empty or its transfer completes.
// Reset (rst_n, async, active low) empties the chain and loads register defaults.
module depth_pixel_backprojection_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pixel_valid,
    output logic                       pixel_ready,
    input  dpb_pkg::dpb_pixel_t        pixel,
    output logic                       point_valid,
    input  logic                       point_ready,
    output dpb_pkg::dpb_point_t        point,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dpb_pkg::ADDR_W-1:0] paddr,
    input  logic [dpb_pkg::DATA_W-1:0] pwdata,
    output logic [dpb_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    dpb_pkg::dpb_cfg_t   cfg;
    dpb_pkg::dpb_stage_t chain [0:dpb_pkg::DVD_W];
    logic                advance;

    // Chain moves when the output slot frees up
    assign advance     = !point_valid || point_ready;
    assign pixel_ready = advance;

    dpb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dpb_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .pixel_valid (pixel_valid),
        .pixel       (pixel),
        .cfg         (cfg),
        .stage_out   (chain[0])
    );

    // Divider chain, one quotient bit per cell
    for (genvar i = 0; i < dpb_pkg::DVD_W; i++)
    begin : g_cell
        dpb_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .focal_x   (cfg.focal_x),
            .focal_y   (cfg.focal_y),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    dpb_post u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .focal_x     (cfg.focal_x),
        .focal_y     (cfg.focal_y),
        .stage_in    (chain[dpb_pkg::DVD_W]),
        .point_valid (point_valid),
        .point       (point)
    );

endmodule
